// File: src/arlp_pkg.sv
// Shared constants and prefix tables for the rangefinder line parser.
`default_nettype none

package arlp_pkg;

  localparam int LINE_BYTES = 32;
  localparam int LC_W       = $clog2(LINE_BYTES + 1);

  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 33;
  localparam int PROD_W  = ACC_W + 4;
  localparam int QUOT_W  = 28;
  localparam int DIST_W  = 29;

  localparam logic [ACC_W-1:0]  ACC_CAP = 33'h1_0000_0000;

  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;
  localparam logic [BYTE_W-1:0] PLUS_BYTE  = 8'h2B;
  localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;

  localparam int STATE_LEN = 6;
  localparam int DATA_LEN  = 2;

  localparam logic signed [DIST_W-1:0] CM_OUT_OF_RANGE = -29'sd1;
  localparam logic signed [DIST_W-1:0] CM_NO_NEW       = -29'sd2;

  // "State;"
  function automatic logic [BYTE_W-1:0] state_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h53;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h3B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "d:"
  function automatic logic [BYTE_W-1:0] data_char(input logic idx);
    return idx ? 8'h3A : 8'h64;
  endfunction

endpackage

`default_nettype wire

// File: src/ascii_range_line_parser_top.sv
// Rangefinder text line parser: byte-wise prefix match, decimal decode and stage machine.
// A read request's distance is registered at its transfer and is valid in the next cycle.
// Throughput: one item per cycle unless a held result stalls; serial bytes and reads
// share the single input path. A pending result is held in the output register and the
// next item is still taken when out_ready is high in the same cycle.
// Reset (synchronous, rst high): first stage, empty line, published value -1.
`default_nettype none

module ascii_range_line_parser_top import arlp_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     kind,
  input  wire logic [BYTE_W-1:0]        rx_byte,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DIST_W-1:0]      distance_cm
);

  typedef enum logic [1:0] {
    ST_WAIT_ZERO  = 2'd0,
    ST_WAIT_DATA  = 2'd1,
    ST_WAIT_CLOSE = 2'd2
  } stage_t;

  typedef enum logic [1:0] {
    LK_START = 2'd0,
    LK_STATE = 2'd1,
    LK_DATA  = 2'd2,
    LK_FAIL  = 2'd3
  } line_kind_t;

  typedef enum logic [1:0] {
    SUB_PFX   = 2'd0,
    SUB_BLANK = 2'd1,
    SUB_DIG   = 2'd2,
    SUB_DONE  = 2'd3
  } sub_t;

  stage_t                    stage, stage_next;
  logic [LC_W-1:0]           line_count, line_count_next;
  line_kind_t                line_kind, line_kind_next;
  sub_t                      sub, sub_next;
  logic                      negative_flag, negative_flag_next;
  logic [ACC_W-1:0]          number_accum, number_accum_next;
  logic [QUOT_W-1:0]         number_quot, number_quot_next;
  logic [QUOT_W-1:0]         pending_cm, pending_cm_next;
  logic signed [DIST_W-1:0]  published_cm, published_cm_next;

  logic                      take;
  logic                      wrap;
  logic [LC_W-1:0]           lc_eff;
  line_kind_t                lk_eff;
  sub_t                      sub_eff;
  logic                      neg_eff;
  logic [ACC_W-1:0]          acc_eff;
  logic [QUOT_W-1:0]         quot_eff;
  logic                      is_digit;
  logic                      is_blank;
  logic                      pfx_hit;
  logic                      pfx_last;
  logic [PROD_W-1:0]         prod;
  logic [ACC_W-1:0]          acc_added;
  logic                      is_state_line;
  logic                      is_data_line;
  logic                      state_zero;
  logic                      data_ok;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign wrap     = line_count >= LC_W'(LINE_BYTES);
  assign lc_eff   = wrap ? '0 : line_count;
  assign lk_eff   = wrap ? LK_START : line_kind;
  assign sub_eff  = wrap ? SUB_PFX : sub;
  assign neg_eff  = wrap ? 1'b0 : negative_flag;
  assign acc_eff  = wrap ? '0 : number_accum;
  assign quot_eff = wrap ? '0 : number_quot;

  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_blank = (rx_byte == 8'h20) || (rx_byte == 8'h09) || (rx_byte == 8'h0B) ||
                    (rx_byte == 8'h0C) || (rx_byte == 8'h0D);

  always_comb begin
    pfx_hit  = 1'b0;
    pfx_last = 1'b0;
    if (lk_eff == LK_DATA) begin
      if (lc_eff < LC_W'(DATA_LEN)) begin
        pfx_hit = rx_byte == data_char(lc_eff[0]);
      end
      pfx_last = lc_eff == LC_W'(DATA_LEN - 1);
    end else begin
      if (lc_eff < LC_W'(STATE_LEN)) begin
        pfx_hit = rx_byte == state_char(lc_eff[2:0]);
      end
      pfx_last = lc_eff == LC_W'(STATE_LEN - 1);
    end
  end

  // acc * 10 + digit, saturating at 2^32
  assign prod = {1'b0, acc_eff, 3'b000} + {3'b000, acc_eff, 1'b0} + PROD_W'(rx_byte[3:0]);
  assign acc_added = (prod > PROD_W'(ACC_CAP)) ? ACC_CAP : prod[ACC_W-1:0];

  assign is_state_line = (lk_eff == LK_STATE) && (sub_eff != SUB_PFX);
  assign is_data_line  = (lk_eff == LK_DATA) && (sub_eff != SUB_PFX);
  assign state_zero    = is_state_line && (acc_eff == '0);
  assign data_ok       = is_data_line && (acc_eff[ACC_W-1:ACC_W-2] == 2'b00) &&
                         !(neg_eff && (acc_eff != '0));

  always_comb begin
    stage_next         = stage;
    line_count_next    = line_count;
    line_kind_next     = line_kind;
    sub_next           = sub;
    negative_flag_next = negative_flag;
    number_accum_next  = number_accum;
    number_quot_next   = number_quot;
    pending_cm_next    = pending_cm;
    published_cm_next  = published_cm;

    if (take) begin
      if (kind) begin
        published_cm_next = CM_NO_NEW;
      end else if (rx_byte == LF_BYTE) begin
        unique case (stage)
          ST_WAIT_ZERO: begin
            if (state_zero) stage_next = ST_WAIT_DATA;
          end
          ST_WAIT_DATA: begin
            if (data_ok) begin
              // quotient by ten is the value before its last digit
              pending_cm_next = quot_eff;
              stage_next      = ST_WAIT_CLOSE;
            end else begin
              stage_next = ST_WAIT_ZERO;
            end
          end
          ST_WAIT_CLOSE: begin
            if (state_zero) begin
              published_cm_next = DIST_W'(pending_cm);
              stage_next        = ST_WAIT_DATA;
            end else begin
              stage_next = ST_WAIT_ZERO;
            end
          end
          default: stage_next = ST_WAIT_ZERO;
        endcase
        line_count_next    = '0;
        line_kind_next     = LK_START;
        sub_next           = SUB_PFX;
        negative_flag_next = 1'b0;
        number_accum_next  = '0;
        number_quot_next   = '0;
      end else begin
        line_count_next    = lc_eff + LC_W'(1);
        line_kind_next     = lk_eff;
        sub_next           = sub_eff;
        negative_flag_next = neg_eff;
        number_accum_next  = acc_eff;
        number_quot_next   = quot_eff;
        unique case (lk_eff)
          LK_START: begin
            if (rx_byte == state_char(3'd0)) begin
              line_kind_next = LK_STATE;
            end else if (rx_byte == data_char(1'b0)) begin
              line_kind_next = LK_DATA;
            end else begin
              line_kind_next = LK_FAIL;
            end
            sub_next = SUB_PFX;
          end
          LK_STATE, LK_DATA: begin
            unique case (sub_eff)
              SUB_PFX: begin
                if (!pfx_hit) begin
                  line_kind_next = LK_FAIL;
                end else if (pfx_last) begin
                  sub_next = SUB_BLANK;
                end
              end
              SUB_BLANK: begin
                priority if (is_blank) begin
                  sub_next = SUB_BLANK;
                end else if (rx_byte == PLUS_BYTE) begin
                  sub_next = SUB_DIG;
                end else if (rx_byte == MINUS_BYTE) begin
                  negative_flag_next = 1'b1;
                  sub_next           = SUB_DIG;
                end else if (is_digit) begin
                  number_quot_next  = acc_eff[QUOT_W-1:0];
                  number_accum_next = acc_added;
                  sub_next          = SUB_DIG;
                end else begin
                  sub_next = SUB_DONE;
                end
              end
              SUB_DIG: begin
                if (is_digit) begin
                  number_quot_next  = acc_eff[QUOT_W-1:0];
                  number_accum_next = acc_added;
                end else begin
                  sub_next = SUB_DONE;
                end
              end
              SUB_DONE: sub_next = SUB_DONE;
            endcase
          end
          LK_FAIL: line_kind_next = LK_FAIL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ST_WAIT_ZERO;
      line_count    <= '0;
      line_kind     <= LK_START;
      sub           <= SUB_PFX;
      negative_flag <= 1'b0;
      number_accum  <= '0;
      number_quot   <= '0;
      pending_cm    <= '0;
      published_cm  <= CM_OUT_OF_RANGE;
      out_valid     <= 1'b0;
    end else begin
      stage         <= stage_next;
      line_count    <= line_count_next;
      line_kind     <= line_kind_next;
      sub           <= sub_next;
      negative_flag <= negative_flag_next;
      number_accum  <= number_accum_next;
      number_quot   <= number_quot_next;
      pending_cm    <= pending_cm_next;
      published_cm  <= published_cm_next;
      if (take && kind) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && kind) begin
      distance_cm <= published_cm;
    end
  end

endmodule

`default_nettype wire

// File: src/arlp_checker.sv
// Port-level assertions for the rangefinder line parser, bound to the top level.
`default_nettype none

module arlp_checker import arlp_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     kind,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DIST_W-1:0] distance_cm
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_cm))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> !out_valid)
    else $error("serial byte produced a result");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind |=> out_valid)
    else $error("read transfer gave no result");

  a_second_read_stale: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind ##1 in_valid && in_ready && kind |=> distance_cm == CM_NO_NEW)
    else $error("repeated read did not report no new data");

endmodule

bind ascii_range_line_parser_top arlp_checker u_arlp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .distance_cm (distance_cm)
);

`default_nettype wire

// File: tb/ascii_range_line_parser_top_tb.sv
// Self-checking testbench for the rangefinder line parser: byte traffic, reads, scoreboard.
module ascii_range_line_parser_top_tb;
  import arlp_pkg::*;

  typedef enum logic [1:0] {AWAIT_ZERO_A, AWAIT_DATA, AWAIT_ZERO_B} meas_stage_t;
  typedef enum logic [1:0] {LN_START, LN_STATE, LN_DATA, LN_JUNK} line_kind_t;
  typedef enum logic [1:0] {FLD_PREFIX, FLD_BLANKS, FLD_DIGITS, FLD_DONE} field_step_t;
  typedef enum int {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_sel_t;

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;
    int unsigned       gap;
  } rx_item_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam longint unsigned MAG_CAP   = 64'h1_0000_0000;
  localparam longint unsigned MAG_LIMIT = 64'h8000_0000;
  localparam logic [BYTE_W-1:0] BLANKS [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     kind = 1'b0;
  logic [BYTE_W-1:0]        rx_byte = '0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic signed [DIST_W-1:0] distance_cm;

  ascii_range_line_parser_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .distance_cm(distance_cm)
  );

  always #5 clk = ~clk;

  // line parser and measurement stage prediction
  string             state_txt = "State;";
  string             data_txt = "d:";
  meas_stage_t       m_stage = AWAIT_ZERO_A;
  int unsigned       line_len = 0;
  line_kind_t        ln_kind = LN_START;
  field_step_t       ln_step = FLD_PREFIX;
  bit                minus_seen = 1'b0;
  longint unsigned   mag = 0;
  logic [31:0]       held_mm = '0;
  logic signed [31:0] shown_cm = CM_OUT_OF_RANGE;

  rx_item_t                 pending[$];
  logic signed [DIST_W-1:0] dist_q[$];
  rx_item_t                 head;
  logic signed [DIST_W-1:0] want_cm;

  int unsigned items_made = 0;
  int unsigned accepted = 0;
  int unsigned reads_checked = 0;
  int unsigned fresh_seen = 0;
  int unsigned fails = 0;
  int unsigned read_pct = 0;
  int unsigned stall_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned ready_roll;
  bit          hold_req = 1'b0;

  function automatic void clear_line();
    line_len   = 0;
    ln_kind    = LN_START;
    ln_step    = FLD_PREFIX;
    minus_seen = 1'b0;
    mag        = 0;
  endfunction

  function automatic void push_digit(logic [BYTE_W-1:0] b);
    mag = mag * 10 + (b - 8'h30);
    if (mag > MAG_CAP) mag = MAG_CAP;
  endfunction

  function automatic void parse_byte(logic [BYTE_W-1:0] b, int unsigned pos);
    bit          digit;
    int unsigned plen;
    digit = (b >= 8'h30) && (b <= 8'h39);
    if (ln_kind == LN_START) begin
      if (b == state_txt[0]) ln_kind = LN_STATE;
      else if (b == data_txt[0]) ln_kind = LN_DATA;
      else ln_kind = LN_JUNK;
      return;
    end
    if (ln_kind == LN_JUNK) return;
    plen = (ln_kind == LN_DATA) ? data_txt.len() : state_txt.len();
    case (ln_step)
      FLD_PREFIX: begin
        if (pos >= plen) ln_kind = LN_JUNK;
        else if ((ln_kind == LN_DATA) ? (b != data_txt[pos]) : (b != state_txt[pos]))
          ln_kind = LN_JUNK;
        else if (pos == plen - 1) ln_step = FLD_BLANKS;
      end
      FLD_BLANKS: begin
        if (b inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D}) return;
        if (b == PLUS_BYTE) begin
          ln_step = FLD_DIGITS;
        end else if (b == MINUS_BYTE) begin
          minus_seen = 1'b1;
          ln_step    = FLD_DIGITS;
        end else if (digit) begin
          push_digit(b);
          ln_step = FLD_DIGITS;
        end else begin
          ln_step = FLD_DONE;
        end
      end
      FLD_DIGITS: begin
        if (digit) push_digit(b);
        else ln_step = FLD_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic void close_line();
    bit state_zero;
    bit data_good;
    state_zero = (ln_kind == LN_STATE) && (ln_step != FLD_PREFIX) && (mag == 0);
    data_good  = (ln_kind == LN_DATA) && (ln_step != FLD_PREFIX) && (mag < MAG_LIMIT) &&
                 !(minus_seen && mag != 0);
    case (m_stage)
      AWAIT_ZERO_A: begin
        if (state_zero) m_stage = AWAIT_DATA;
      end
      AWAIT_DATA: begin
        if (data_good) begin
          held_mm = mag[31:0];
          m_stage = AWAIT_ZERO_B;
        end else begin
          m_stage = AWAIT_ZERO_A;
        end
      end
      default: begin
        if (state_zero) begin
          shown_cm = held_mm / 10;
          m_stage  = AWAIT_DATA;
        end else begin
          m_stage = AWAIT_ZERO_A;
        end
      end
    endcase
  endfunction

  function automatic void take_serial(logic [BYTE_W-1:0] b);
    if (line_len >= LINE_BYTES) clear_line();
    if (b == LF_BYTE) begin
      close_line();
      clear_line();
    end else begin
      parse_byte(b, line_len);
      line_len++;
    end
  endfunction

  function automatic void note_fail(string msg);
    fails++;
    if (fails <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  // stimulus building
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (items_made % 320 < 64) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_item(logic k, logic [BYTE_W-1:0] b);
    rx_item_t it;
    it.kind    = k;
    it.rx_byte = b;
    it.gap     = pick_gap();
    pending.push_back(it);
    items_made++;
  endfunction

  function automatic void add_byte(logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < read_pct) add_item(KIND_READ, BYTE_W'($urandom_range(0, 255)));
    add_item(KIND_BYTE, b);
  endfunction

  function automatic void add_text(string t);
    for (int i = 0; i < t.len(); i++) add_byte(t[i]);
  endfunction

  function automatic void add_number(longint unsigned m, sign_sel_t sgn, bit no_digits);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
      add_byte(BLANKS[$urandom_range(0, 4)]);
    if (sgn == SIGN_PLUS) add_byte(PLUS_BYTE);
    else if (sgn == SIGN_MINUS) add_byte(MINUS_BYTE);
    if (!no_digits) begin
      if ($urandom_range(0, 5) == 0) add_byte(8'h30);
      add_text($sformatf("%0d", m));
    end
    case ($urandom_range(0, 5))
      0: add_text("mm");
      1: add_text(" 42");
      2: add_byte(8'h3B);
      default: ;
    endcase
  endfunction

  function automatic void add_state_line();
    add_text(state_txt);
    if ($urandom_range(0, 9) < 8)
      add_number(0, sign_sel_t'($urandom_range(0, 2)), $urandom_range(0, 4) == 0);
    else
      add_number(64'($urandom_range(1, 99)), sign_sel_t'($urandom_range(0, 2)), 1'b0);
    add_byte(LF_BYTE);
  endfunction

  task automatic add_traffic(int unsigned upto);
    int unsigned     r;
    int unsigned     idx;
    longint unsigned m;
    logic [7:0]      b;
    string           t;
    while (items_made < upto) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_state_line();
        r = $urandom_range(0, 99);
        if (r < 35) m = 64'($urandom_range(0, 9999));
        else if (r < 60) m = 64'($urandom & 32'h7FFF_FFFF);
        else if (r < 65) m = MAG_LIMIT - 1;
        else if (r < 70) m = MAG_LIMIT;
        else if (r < 75) m = MAG_CAP - 1 + $urandom_range(0, 2);
        else if (r < 80) m = {$urandom, $urandom} % 64'd1_000_000_000_000_000;
        else if (r < 90) m = 0;
        else m = 64'($urandom_range(10, 99999));
        add_text(data_txt);
        add_number(m, ($urandom_range(0, 9) == 0) ? SIGN_MINUS
                      : sign_sel_t'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
        add_byte(LF_BYTE);
        add_state_line();
        if ($urandom_range(0, 9) < 7) add_item(KIND_READ, BYTE_W'($urandom_range(0, 255)));
      end else if (r < 80) begin
        case ($urandom_range(0, 3))
          0: begin
            repeat ($urandom_range(33, 70)) begin
              b = 8'($urandom_range(0, 255));
              add_byte((b == LF_BYTE) ? 8'hFF : b);
            end
          end
          // restart lands on a state line
          1: begin
            repeat (LINE_BYTES) add_byte(BYTE_W'(8'h41 + $urandom_range(0, 25)));
            add_text("State;0");
          end
          // full line: the terminator falls after the restart
          2: begin
            add_text("State;0");
            repeat (LINE_BYTES - 7) add_byte(8'h20);
          end
          default: begin
            add_text("State;0");
            repeat (LINE_BYTES - 8) add_byte(8'h20);
          end
        endcase
        add_byte(LF_BYTE);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 12)) add_byte(BYTE_W'($urandom_range(0, 255)));
        add_byte(LF_BYTE);
      end else begin
        t   = ($urandom_range(0, 1) == 0) ? state_txt : data_txt;
        idx = $urandom_range(0, t.len() - 1);
        for (int i = 0; i < t.len(); i++) add_byte((i == idx) ? (t[i] ^ 8'h20) : t[i]);
        add_text("0");
        add_byte(LF_BYTE);
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (accepted != items_made || dist_q.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending.size() != 0 && pending[0].gap == 0) begin
        head = pending.pop_front();
        in_valid <= 1'b1;
        kind     <= head.kind;
        rx_byte  <= head.rx_byte;
      end else begin
        if (pending.size() != 0) pending[0].gap--;
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    rx_cycle++;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = 400;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_cycle % 1500 < 250) begin
      out_ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = (ready_roll < 97) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (dist_q.size() == 0) begin
          note_fail($sformatf("distance_cm %0d with no read outstanding", distance_cm));
        end else begin
          want_cm = dist_q.pop_front();
          reads_checked++;
          if (want_cm >= 0) fresh_seen++;
          if (distance_cm !== want_cm)
            note_fail($sformatf("distance_cm expected %0d got %0d", want_cm, distance_cm));
        end
      end
      if (in_valid && in_ready) begin
        accepted++;
        if (kind == KIND_READ) begin
          dist_q.push_back(shown_cm[DIST_W-1:0]);
          shown_cm = CM_NO_NEW;
        end else begin
          take_serial(rx_byte);
        end
      end
    end
  end

  initial begin
    add_item(KIND_READ, 8'hFF);
    add_text("State;0\n");
    add_text("d:1234\n");
    add_text("State;0\n");
    add_item(KIND_READ, 8'h00);
    add_item(KIND_READ, 8'h5A);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    drain();
    read_pct = 4;
    add_traffic(900);
    drain();
    add_traffic(1950);
    hold_req = 1'b1;
    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d transfers in and %0d distance reads (%0d fresh), %0d failures.",
             accepted, reads_checked, fresh_seen, fails);
    $display("Traffic: state/data/state sequences plus long, broken and noise lines.");
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d of %0d items taken, %0d reads outstanding",
             accepted, items_made, dist_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
src/arlp_pkg.sv
src/ascii_range_line_parser_top.sv
src/arlp_checker.sv
tb/ascii_range_line_parser_top_tb.sv
